### rtl/core/text_mode_console_writer_unit_assert.svh
// assertion macros for the console writer
`ifndef TEXT_MODE_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_UNIT_ASSERT_SVH

// same-cycle implication
`define TMCW_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TMCW_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tmcw_pkg.sv
package tmcw_pkg;

	localparam int unsigned COLUMNS     = 80;
	localparam int unsigned ROWS        = 24;
	localparam int unsigned CELL_COUNT  = COLUMNS * ROWS;
	localparam int unsigned SHIFT_CELLS = (ROWS - 1) * COLUMNS;
	localparam int unsigned AW          = $clog2(CELL_COUNT);
	localparam int unsigned CUR_W       = $clog2(CELL_COUNT + 1);
	localparam int unsigned COL_W       = $clog2(COLUMNS);

	localparam logic [8:0] CODE_NEWLINE   = 9'd10;
	localparam logic [8:0] CODE_BACKSPACE = 9'h100;
	localparam logic [7:0] BLANK_CHAR     = 8'h20;
	localparam logic [7:0] ATTR_RESET     = 8'h07;
	localparam logic       REG_ATTR       = 1'b0;
	localparam logic       OP_PUT         = 1'b0;
	localparam logic       OP_READ        = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [8:0]  char_code;
		logic [10:0] cell_address;
	} req_word_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [10:0] cursor_position;
	} rsp_word_t;

	typedef struct packed {
		logic load_req;
		logic exec_put;
		logic exec_read;
		logic blank;
		logic copy_step;
		logic copy_end;
		logic sweep;
		logic rsp_load;
	} cmd_t;

	typedef struct packed {
		logic op_read;
		logic cursor_over;
		logic copy_last;
		logic copy_zero;
		logic sweep_last;
		logic rsp_free;
	} sts_t;

endpackage

### rtl/core/tmcw_ctrl.sv
module tmcw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tmcw_pkg::sts_t sts,
	output tmcw_pkg::cmd_t cmd
);
	import tmcw_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_POST  = 3'd3;
	localparam logic [2:0] ST_COPY  = 3'd4;
	localparam logic [2:0] ST_SHEND = 3'd5;
	localparam logic [2:0] ST_WIPE  = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.op_read) begin
					cmd.exec_read = 1'b1;
					state_d       = ST_OUT;
				end else begin
					cmd.exec_put = 1'b1;
					state_d      = ST_POST;
				end
			end
			ST_POST: begin
				if (sts.cursor_over) begin
					state_d = ST_COPY;
				end else begin
					cmd.blank = 1'b1;
					state_d   = ST_OUT;
				end
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (sts.copy_last) state_d = ST_SHEND;
			end
			ST_SHEND: begin
				cmd.copy_end = 1'b1;
				state_d      = ST_WIPE;
			end
			ST_WIPE: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = ST_POST;
			end
			ST_OUT: begin
				if (sts.rsp_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/tmcw_datapath.sv
module tmcw_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          attr,
	input  tmcw_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output tmcw_pkg::rsp_word_t rsp,
	input  tmcw_pkg::cmd_t      cmd,
	output tmcw_pkg::sts_t      sts
);
	import tmcw_pkg::*;

	logic [15:0]      mem [CELL_COUNT];
	logic [15:0]      rd_q;
	req_word_t        req_q;
	logic             rd_ok_q;
	logic [CUR_W-1:0] cursor_q;
	logic [COL_W-1:0] col_q;
	logic [AW-1:0]    copy_idx_q;
	logic [AW-1:0]    sweep_idx_q;
	logic             cp_wr_s1;
	logic [AW-1:0]    cp_addr_s1;
	logic             rsp_valid_q;
	rsp_word_t        rsp_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [15:0]      wdata;
	logic             re;
	logic [AW-1:0]    raddr;
	logic             in_store;
	logic             is_nl;
	logic             is_bs;

	assign in_store = (cursor_q < CUR_W'(CELL_COUNT));
	assign is_nl    = (req_q.char_code == CODE_NEWLINE);
	assign is_bs    = (req_q.char_code == CODE_BACKSPACE);

	always_comb begin
		we    = 1'b0;
		waddr = cursor_q[AW-1:0];
		wdata = {attr, BLANK_CHAR};
		if (cp_wr_s1) begin
			we    = 1'b1;
			waddr = cp_addr_s1;
			wdata = rd_q;
		end else if (cmd.sweep) begin
			we    = 1'b1;
			waddr = sweep_idx_q;
			wdata = '0;
		end else if (cmd.blank) begin
			we    = in_store;
		end else if (cmd.exec_put && !is_nl && !is_bs) begin
			we    = in_store;
			wdata = {attr, req_q.char_code[7:0]};
		end
	end

	always_comb begin
		re    = cmd.exec_read || cmd.copy_step;
		raddr = cmd.copy_step ? (copy_idx_q + AW'(COLUMNS)) : AW'(req_q.cell_address);
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;
		if (cmd.exec_read) rd_ok_q <= ({21'd0, req_q.cell_address} < 32'(CELL_COUNT));
		cp_addr_s1 <= copy_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			col_q       <= '0;
			copy_idx_q  <= '0;
			sweep_idx_q <= '0;
			cp_wr_s1    <= 1'b0;
		end else begin
			cp_wr_s1 <= cmd.copy_step;
			if (cmd.exec_put) begin
				if (is_nl) begin
					cursor_q <= cursor_q + (CUR_W'(COLUMNS) - CUR_W'(col_q));
					col_q    <= '0;
				end else if (is_bs) begin
					if (cursor_q != '0) begin
						cursor_q <= cursor_q - CUR_W'(1);
						col_q    <= (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - COL_W'(1);
					end
				end else begin
					cursor_q <= cursor_q + CUR_W'(1);
					col_q    <= (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
				end
			end
			if (cmd.copy_step) begin
				copy_idx_q <= sts.copy_last ? '0 : copy_idx_q + AW'(1);
			end
			if (cmd.copy_end) begin
				cursor_q    <= cursor_q - CUR_W'(COLUMNS);
				sweep_idx_q <= AW'(SHIFT_CELLS);
			end else if (cmd.sweep) begin
				sweep_idx_q <= sts.sweep_last ? '0 : sweep_idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q.cell_value      <= (req_q.operation == OP_READ && rd_ok_q) ? rd_q : 16'd0;
			rsp_q.cursor_position <= 11'(cursor_q);
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp             = rsp_q;
	assign sts.op_read     = (req_q.operation == OP_READ);
	assign sts.cursor_over = !in_store;
	assign sts.copy_last   = (copy_idx_q == AW'(SHIFT_CELLS - 1));
	assign sts.copy_zero   = (copy_idx_q == '0);
	assign sts.sweep_last  = (sweep_idx_q == AW'(CELL_COUNT - 1));
	assign sts.rsp_free    = !rsp_valid_q || rsp_ready;

endmodule

### rtl/core/text_mode_console_writer_unit.sv
// channel   dir   handshake             word
// config    in    psel/penable/pwrite   paddr, pwdata, prdata (text attribute)
// req       in    req_valid/req_ready   operation, char_code, cell_address
// rsp       out   rsp_valid/rsp_ready   cell_value, cursor_position
//
// put: after accept the word passes EXEC, POST and OUT, the result is registered as OUT ends
// read: after accept the word passes EXEC and OUT, the result is registered as OUT ends
// a put that scrolls first copies (ROWS-1)*COLUMNS cells up one row in COPY through the
// single screen ram port pair, then passes SHEND and clears the last row in WIPE
// after reset a clearing pass over all ROWS*COLUMNS cells (1920) runs, req_ready low
// one word at a time; a held result stalls the next word only at its own end
module text_mode_console_writer_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                req_valid,
	output logic                req_ready,
	input  tmcw_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output tmcw_pkg::rsp_word_t rsp
);
	import tmcw_pkg::*;

	`include "text_mode_console_writer_unit_assert.svh"

	logic [7:0] attr_q;
	cmd_t       cmd;
	sts_t       sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ATTR) ? {24'd0, attr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ATTR) begin
			attr_q <= pwdata[7:0];
		end
	end

	tmcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tmcw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.attr      (attr_q),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

	`TMCW_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
	`TMCW_ASSERT_NOW(a_idle_cursor_in_store, req_ready, !sts.cursor_over, "cursor out of store")
	`TMCW_ASSERT_NOW(a_idle_copy_reset, req_ready, sts.copy_zero, "copy counter not rewound")
	`TMCW_ASSERT_NOW(a_load_when_free, cmd.rsp_load, sts.rsp_free, "result overwritten")

endmodule

### tb/sv/text_mode_console_writer_unit_tb.sv
module text_mode_console_writer_unit_tb;
	import tmcw_pkg::*;

	localparam int unsigned STUCK_LIMIT = 12000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned PHASE_WORDS = 300;
	localparam logic [2:0] ATTR_ADDR = 3'(4 * REG_ATTR);

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_ready;
	req_word_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b1;
	rsp_word_t rsp;

	text_mode_console_writer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// console shadow state
	logic [15:0] screen_image [0:CELL_COUNT-1];
	int unsigned cursor_cell = 0;
	logic [7:0] text_attr = ATTR_RESET;

	req_word_t pending_req [$];
	rsp_word_t awaited_rsp [$];
	rsp_word_t oldest_rsp;

	int unsigned mismatches = 0;
	int unsigned req_sent = 0;
	int unsigned rsp_seen = 0;
	int unsigned req_gap = 0;
	int unsigned rsp_stall = 0;
	int unsigned stuck_cycles = 0;
	bit req_calm = 1'b0;
	bit rsp_calm = 1'b0;

	function automatic rsp_word_t console_step(input req_word_t w);
		rsp_word_t r;
		r = '0;
		if (w.operation == OP_READ) begin
			if (w.cell_address < CELL_COUNT)
				r.cell_value = screen_image[w.cell_address];
		end else begin
			if (w.char_code == CODE_NEWLINE) begin
				cursor_cell = cursor_cell + COLUMNS - (cursor_cell % COLUMNS);
			end else if (w.char_code == CODE_BACKSPACE) begin
				if (cursor_cell > 0)
					cursor_cell = cursor_cell - 1;
			end else begin
				if (cursor_cell < CELL_COUNT)
					screen_image[cursor_cell] = {text_attr, w.char_code[7:0]};
				cursor_cell = cursor_cell + 1;
			end
			// scroll up one row and clear from the cursor to the end
			if (cursor_cell / COLUMNS >= ROWS) begin
				for (int unsigned i = 0; i < SHIFT_CELLS; i++)
					screen_image[i] = screen_image[i + COLUMNS];
				cursor_cell = cursor_cell - COLUMNS;
				for (int unsigned i = cursor_cell; i < CELL_COUNT; i++)
					screen_image[i] = '0;
			end
			if (cursor_cell < CELL_COUNT)
				screen_image[cursor_cell] = {text_attr, BLANK_CHAR};
		end
		r.cursor_position = cursor_cell[10:0];
		return r;
	endfunction

	function automatic req_word_t put_word(input logic [8:0] code);
		req_word_t w;
		w.operation = OP_PUT;
		w.char_code = code;
		w.cell_address = 11'($urandom_range(0, 2047));
		return w;
	endfunction

	function automatic req_word_t read_word(input logic [10:0] addr);
		req_word_t w;
		w.operation = OP_READ;
		w.char_code = 9'($urandom_range(0, 511));
		w.cell_address = addr;
		return w;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic queue_random(input int unsigned count);
		req_word_t w;
		int unsigned sel;
		for (int unsigned n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			w.operation = OP_PUT;
			w.char_code = 9'($urandom_range(0, 511));
			w.cell_address = 11'($urandom_range(0, 2047));
			if (sel < 30) begin
				w.operation = OP_READ;
				if (sel < 25)
					w.cell_address = 11'($urandom_range(0, CELL_COUNT - 1));
			end else if (sel < 38) begin
				w.char_code = CODE_NEWLINE;
			end else if (sel < 43) begin
				w.char_code = CODE_BACKSPACE;
			end
			pending_req.push_back(w);
		end
	endtask

	task automatic wait_idle;
		while (pending_req.size() != 0 || req_valid || awaited_rsp.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_attr(input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ATTR_ADDR;
		pwdata <= ($urandom & 32'hFFFF_FF00) | 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		text_attr = value;
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				awaited_rsp.push_back(console_step(req));
				req_sent++;
				if (req_sent % 64 == 0)
					req_calm = ($urandom_range(0, 3) == 0);
				req_gap = req_calm ? 0 : $urandom_range(0, 7);
			end
			if (req_valid && !req_ready) begin
			end else if (req_gap != 0) begin
				req_valid <= 1'b0;
				req_gap--;
			end else if (pending_req.size() != 0) begin
				req_valid <= 1'b1;
				req <= pending_req.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					report_mismatch($sformatf("word with nothing awaited, cursor %0d",
						rsp.cursor_position));
				end else begin
					oldest_rsp = awaited_rsp.pop_front();
					if (rsp.cell_value !== oldest_rsp.cell_value)
						report_mismatch($sformatf("cell_value %h, predicted %h",
							rsp.cell_value, oldest_rsp.cell_value));
					if (rsp.cursor_position !== oldest_rsp.cursor_position)
						report_mismatch($sformatf("cursor_position %0d, predicted %0d",
							rsp.cursor_position, oldest_rsp.cursor_position));
				end
				rsp_seen++;
				if (rsp_seen % 64 == 0)
					rsp_calm = ($urandom_range(0, 3) == 0);
				rsp_stall = rsp_calm ? 0 : $urandom_range(0, 7);
			end
			if (rsp_stall != 0) begin
				rsp_ready <= 1'b0;
				rsp_stall--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles == STUCK_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		for (int unsigned i = 0; i < CELL_COUNT; i++)
			screen_image[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset attribute, cursor edges and odd codes
		pending_req.push_back(read_word(11'd0));
		pending_req.push_back(put_word(CODE_BACKSPACE));
		pending_req.push_back(put_word(9'd0));
		pending_req.push_back(put_word(9'd255));
		pending_req.push_back(put_word(9'd266));
		pending_req.push_back(put_word(9'd511));
		pending_req.push_back(put_word(9'd321));
		pending_req.push_back(put_word(CODE_BACKSPACE));
		pending_req.push_back(put_word(9'h020));
		pending_req.push_back(put_word(CODE_NEWLINE));
		pending_req.push_back(read_word(11'd1));
		pending_req.push_back(read_word(11'd2));
		pending_req.push_back(read_word(11'd80));
		pending_req.push_back(read_word(11'd1919));
		pending_req.push_back(read_word(11'd1920));
		pending_req.push_back(read_word(11'd2047));
		pending_req.push_back(read_word(11'd1024));
		wait_idle();

		write_attr(8'hFF);
		queue_random(PHASE_WORDS);
		wait_idle();
		write_attr(8'h00);
		queue_random(PHASE_WORDS);
		wait_idle();
		for (int k = 0; k < 3; k++) begin
			write_attr(8'($urandom_range(0, 255)));
			queue_random(PHASE_WORDS);
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/tmcw_pkg.sv
rtl/core/tmcw_ctrl.sv
rtl/core/tmcw_datapath.sv
rtl/core/text_mode_console_writer_unit.sv
tb/sv/text_mode_console_writer_unit_tb.sv
